### design/pno_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pno_pkg;

  // Offset distance register, unsigned Q15.16.
  localparam int DIST_WIDTH = 31;
  // Normalized chord magnitudes and unit components sit below 2^31.
  localparam int MAG_WIDTH = 31;
  // Square root of a 63-bit sum: one result bit per step.
  localparam int ROOT_STEPS = 32;
  // Quotient of (a << 30) / r fits in 31 bits.
  localparam int QUOT_STEPS = 31;
  // Unit vector is Q1.30; products are rounded half up back to Q15.16.
  localparam int UNIT_FRAC = 30;

  typedef enum logic [3:0] {
    N_IDLE,
    N_NORM,
    N_SQX,
    N_SQY,
    N_SQS,
    N_SQRT,
    N_DIVX,
    N_DIVY,
    N_MULX,
    N_MULY,
    N_MULE
  } norm_state_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_EMIT
  } top_state_t;

  typedef struct packed {
    logic [MAG_WIDTH-1:0] mag_x;
    logic [MAG_WIDTH-1:0] mag_y;
    logic                 neg_x;
    logic                 neg_y;
    logic                 zero;
  } norm_res_t;

endpackage

`default_nettype wire

### design/pno_point_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pno_point_if #(
  parameter int COORD_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] point_x;
  logic signed [COORD_WIDTH-1:0] point_y;
  logic                          last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink (input valid, point_x, point_y, last_point, output ready);
endinterface

`default_nettype wire

### design/pno_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pno_result_if #(
  parameter int COORD_WIDTH = 32
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] plus_x;
  logic signed [COORD_WIDTH-1:0] plus_y;
  logic signed [COORD_WIDTH-1:0] minus_x;
  logic signed [COORD_WIDTH-1:0] minus_y;
  logic                          zero_chord;
  logic                          last_result;

  modport source (output valid, plus_x, plus_y, minus_x, minus_y, zero_chord, last_result,
                  input ready);
  modport sink (input valid, plus_x, plus_y, minus_x, minus_y, zero_chord, last_result,
                output ready);
endinterface

`default_nettype wire

### design/pno_norm_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module pno_norm_unit #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [COORD_WIDTH-1:0]  x0,
  input  logic signed [COORD_WIDTH-1:0]  y0,
  input  logic signed [COORD_WIDTH-1:0]  x2,
  input  logic signed [COORD_WIDTH-1:0]  y2,
  input  logic [pno_pkg::DIST_WIDTH-1:0] distance,
  output logic                           done,
  output pno_pkg::norm_res_t             res
);
  import pno_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int NW = (CW + 1 > 32) ? CW + 1 : 32;
  localparam logic [61:0] ROUND_ONE = 62'd1 << (UNIT_FRAC - 1);
  localparam logic [4:0] ROOT_LAST = 5'(ROOT_STEPS - 1);
  localparam logic [4:0] QUOT_LAST = 5'(QUOT_STEPS - 1);

  norm_state_t state, state_next;

  logic signed [CW:0] tx, ty;
  logic [CW:0]        abs_x, abs_y;
  logic [NW-1:0]      ax, ay, or_v;
  logic               too_big, too_small;

  logic [61:0] prod, prod_c, rnd;
  logic [30:0] mul_a, mul_b;
  logic [63:0] v, root, bitm, root_bit;
  logic [31:0] rem;
  logic [29:0] quo;
  logic [30:0] ux, uy;
  logic [4:0]  cnt;
  logic        nb;
  logic [32:0] t;
  logic [63:0] sub_a, sub_b;
  logic [64:0] diff;
  logic        ge;

  assign tx = {y2[CW-1], y2} - {y0[CW-1], y0};
  assign ty = {x0[CW-1], x0} - {x2[CW-1], x2};
  assign abs_x = tx[CW] ? (~tx + 1'b1) : tx;
  assign abs_y = ty[CW] ? (~ty + 1'b1) : ty;

  // The larger magnitude has the same leading bit as the OR of both.
  assign or_v = ax | ay;
  assign too_big = |or_v[NW-1:31];
  assign too_small = !or_v[30];

  // Shared multiplier: squares first, then distance times unit components.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      N_SQX: begin
        mul_a = ax[30:0];
        mul_b = ax[30:0];
      end
      N_SQY: begin
        mul_a = ay[30:0];
        mul_b = ay[30:0];
      end
      N_MULX: begin
        mul_a = distance;
        mul_b = ux;
      end
      N_MULY: begin
        mul_a = distance;
        mul_b = uy;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_c = mul_a * mul_b;
  assign rnd = prod + ROUND_ONE;

  // Shared subtractor: square-root trial and restoring division steps.
  assign root_bit = root + bitm;
  assign nb = (cnt == QUOT_LAST) ? ((state == N_DIVX) ? ax[0] : ay[0]) : 1'b0;
  assign t = {rem, nb};

  always_comb begin
    if (state == N_SQRT) begin
      sub_a = v;
      sub_b = root_bit;
    end else begin
      sub_a = 64'(t);
      sub_b = root;
    end
  end

  assign diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign ge = !diff[64];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      N_IDLE: begin
        if (start && (abs_x != '0 || abs_y != '0)) begin
          state_next = N_NORM;
        end
      end
      N_NORM: begin
        if (!too_big && !too_small) begin
          state_next = N_SQX;
        end
      end
      N_SQX: state_next = N_SQY;
      N_SQY: state_next = N_SQS;
      N_SQS: state_next = N_SQRT;
      N_SQRT: begin
        if (cnt == '0) begin
          state_next = N_DIVX;
        end
      end
      N_DIVX: begin
        if (cnt == '0) begin
          state_next = N_DIVY;
        end
      end
      N_DIVY: begin
        if (cnt == '0) begin
          state_next = N_MULX;
        end
      end
      N_MULX: state_next = N_MULY;
      N_MULY: state_next = N_MULE;
      N_MULE: state_next = N_IDLE;
      default: state_next = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == N_MULE) ||
              (state == N_IDLE && start && abs_x == '0 && abs_y == '0);
    end
  end

  always_ff @(posedge clk) begin
    prod <= prod_c;
    case (state)
      N_IDLE: begin
        if (start) begin
          ax <= NW'(abs_x);
          ay <= NW'(abs_y);
          res.neg_x <= tx[CW];
          res.neg_y <= ty[CW];
          res.zero <= (abs_x == '0 && abs_y == '0);
          res.mag_x <= '0;
          res.mag_y <= '0;
        end
      end
      N_NORM: begin
        if (too_big) begin
          ax <= ax >> 1;
          ay <= ay >> 1;
        end else if (too_small) begin
          ax <= ax << 1;
          ay <= ay << 1;
        end
      end
      N_SQY: begin
        v <= 64'(prod);
      end
      N_SQS: begin
        v <= v + 64'(prod);
        root <= '0;
        bitm <= 64'd1 << 62;
        cnt <= ROOT_LAST;
      end
      N_SQRT: begin
        if (ge) begin
          v <= diff[63:0];
          root <= (root >> 1) + bitm;
        end else begin
          root <= root >> 1;
        end
        bitm <= bitm >> 2;
        if (cnt == '0) begin
          rem <= {2'b00, ax[30:1]};
          quo <= '0;
          cnt <= QUOT_LAST;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
      N_DIVX, N_DIVY: begin
        if (cnt == '0) begin
          if (state == N_DIVX) begin
            ux <= {quo, ge};
            rem <= {2'b00, ay[30:1]};
            quo <= '0;
            cnt <= QUOT_LAST;
          end else begin
            uy <= {quo, ge};
          end
        end else begin
          rem <= ge ? diff[31:0] : t[31:0];
          quo <= {quo[28:0], ge};
          cnt <= cnt - 1'b1;
        end
      end
      N_MULY: begin
        res.mag_x <= rnd[60:30];
      end
      N_MULE: begin
        res.mag_y <= rnd[60:30];
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### design/polyline_normal_offset.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel      Dir  Payload
// point_in     in   point_x, point_y, last_point
// result_out   out  plus_x, plus_y, minus_x, minus_y, zero_chord, last_result
// cfg_we/wdata in   offset_distance (unsigned Q15.16)
//
// A point that closes a chord runs s normalization shifts (0 to 30), then 32 root and 62
// divide steps on the one shared subtractor, with setup, squares, offsets and handoff, and
// sends n results (1 to 3). A zero-length chord skips the unit; a point that only fills the
// window sends no result. Reset clears the window, the count and the register. A stalled
// output register holds off the next result, and a request is taken only after the previous
// point has sent all of its.
module polyline_normal_offset #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [pno_pkg::DIST_WIDTH-1:0] cfg_wdata,
  pno_point_if.sink                      point_in,
  pno_result_if.source                   result_out
);
  import pno_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int SW = ((CW > 32) ? CW : 32) + 2;

  top_state_t state, state_next;

  logic [DIST_WIDTH-1:0] distance;
  logic signed [CW-1:0]  win_x [2];
  logic signed [CW-1:0]  win_y [2];
  logic [1:0]            seen;
  logic signed [CW-1:0]  cur_x, cur_y;
  logic                  cur_last;
  logic                  blank, from_w0;
  logic [1:0]            emit_n, emit_k, src;
  logic                  accept, unit_start, unit_done, emit_fire, emit_end;
  norm_res_t             nres;

  logic signed [CW-1:0] sel_x, sel_y;
  logic signed [SW-1:0] ox, oy, px, py;

  logic                 ovalid;
  logic signed [CW-1:0] o_plus_x, o_plus_y, o_minus_x, o_minus_y;
  logic                 o_zero, o_last;

  function automatic logic [CW-1:0] sat_w(input logic signed [SW-1:0] s);
    logic over, under;
    over = !s[SW-1] && (s[SW-2:CW-1] != '0);
    under = s[SW-1] && !(&s[SW-2:CW-1]);
    if (over) begin
      return {1'b0, {(CW - 1){1'b1}}};
    end else if (under) begin
      return {1'b1, {(CW - 1){1'b0}}};
    end
    return s[CW-1:0];
  endfunction

  pno_norm_unit #(
    .COORD_WIDTH(CW)
  ) u_norm (
    .clk     (clk),
    .rst     (rst),
    .start   (unit_start),
    .x0      (win_x[0]),
    .y0      (win_y[0]),
    .x2      (point_in.point_x),
    .y2      (point_in.point_y),
    .distance(distance),
    .done    (unit_done),
    .res     (nres)
  );

  assign accept = point_in.valid && point_in.ready;
  assign emit_fire = (state == S_EMIT) && (!ovalid || result_out.ready);
  assign emit_end = emit_fire && (emit_k == emit_n - 2'd1);

  always_comb begin
    state_next = state;
    point_in.ready = 1'b0;
    unit_start = 1'b0;
    case (state)
      S_IDLE: begin
        point_in.ready = 1'b1;
        if (point_in.valid) begin
          if (seen[1]) begin
            unit_start = 1'b1;
            state_next = S_CALC;
          end else if (point_in.last_point) begin
            state_next = S_EMIT;
          end
        end
      end
      S_CALC: begin
        if (unit_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_end) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      distance <= '0;
    end else if (cfg_we) begin
      distance <= cfg_wdata;
    end
  end

  // Window, point count and the plan of results for the current request.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
      win_x[0] <= '0;
      win_x[1] <= '0;
      win_y[0] <= '0;
      win_y[1] <= '0;
      emit_k <= '0;
      emit_n <= '0;
      blank <= 1'b0;
      from_w0 <= 1'b0;
    end else begin
      if (accept) begin
        cur_x <= point_in.point_x;
        cur_y <= point_in.point_y;
        cur_last <= point_in.last_point;
        emit_k <= '0;
        blank <= !seen[1];
        from_w0 <= (seen == 2'd2);
        if (seen[1]) begin
          emit_n <= ((seen == 2'd2) ? 2'd2 : 2'd1) + {1'b0, point_in.last_point};
        end else begin
          emit_n <= seen + 2'd1;
          if (!point_in.last_point) begin
            win_x[0] <= win_x[1];
            win_y[0] <= win_y[1];
            win_x[1] <= point_in.point_x;
            win_y[1] <= point_in.point_y;
            seen <= seen + 2'd1;
          end
        end
      end
      if (emit_fire) begin
        emit_k <= emit_k + 2'd1;
      end
      if (emit_end) begin
        if (cur_last) begin
          seen <= '0;
          win_x[0] <= '0;
          win_x[1] <= '0;
          win_y[0] <= '0;
          win_y[1] <= '0;
        end else begin
          win_x[0] <= win_x[1];
          win_y[0] <= win_y[1];
          win_x[1] <= cur_x;
          win_y[1] <= cur_y;
          seen <= 2'd3;
        end
      end
    end
  end

  // The first result of the third point of a line is for the oldest window point.
  assign src = emit_k + (from_w0 ? 2'd0 : 2'd1);

  always_comb begin
    case (src)
      2'd0: begin
        sel_x = win_x[0];
        sel_y = win_y[0];
      end
      2'd1: begin
        sel_x = win_x[1];
        sel_y = win_y[1];
      end
      default: begin
        sel_x = cur_x;
        sel_y = cur_y;
      end
    endcase
  end

  always_comb begin
    px = SW'(sel_x);
    py = SW'(sel_y);
    ox = nres.neg_x ? -signed'(SW'(nres.mag_x)) : signed'(SW'(nres.mag_x));
    oy = nres.neg_y ? -signed'(SW'(nres.mag_y)) : signed'(SW'(nres.mag_y));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (emit_fire) begin
      ovalid <= 1'b1;
    end else if (result_out.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      o_last <= cur_last && emit_end;
      if (blank) begin
        o_plus_x <= '0;
        o_plus_y <= '0;
        o_minus_x <= '0;
        o_minus_y <= '0;
        o_zero <= 1'b0;
      end else begin
        o_plus_x <= sat_w(px + ox);
        o_plus_y <= sat_w(py + oy);
        o_minus_x <= sat_w(px - ox);
        o_minus_y <= sat_w(py - oy);
        o_zero <= nres.zero;
      end
    end
  end

  assign result_out.valid = ovalid;
  assign result_out.plus_x = o_plus_x;
  assign result_out.plus_y = o_plus_y;
  assign result_out.minus_x = o_minus_x;
  assign result_out.minus_y = o_minus_y;
  assign result_out.zero_chord = o_zero;
  assign result_out.last_result = o_last;

endmodule

`default_nettype wire

### test/polyline_normal_offset_tb.sv
`timescale 1ns / 1ps

module polyline_normal_offset_tb;

  localparam int CW = 32;
  localparam int DW = pno_pkg::DIST_WIDTH;
  localparam longint COORD_MAX = (longint'(1) << (CW - 1)) - 1;
  localparam longint COORD_MIN = -(longint'(1) << (CW - 1));
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW - 1){1'b0}}};
  localparam logic [DW-1:0] DIST_MAX = {DW{1'b1}};
  localparam int SETTLE_CYCLES = 200;
  localparam int MAX_REPORTS = 40;

  typedef enum int {
    LINE_SCATTER,
    LINE_WALK,
    LINE_CORNERS,
    LINE_CREEP
  } line_style_t;

  typedef struct packed {
    logic signed [CW-1:0] plus_x;
    logic signed [CW-1:0] plus_y;
    logic signed [CW-1:0] minus_x;
    logic signed [CW-1:0] minus_y;
    logic                 zero_chord;
    logic                 last_result;
  } offset_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [DW-1:0] cfg_wdata;

  pno_point_if #(.COORD_WIDTH(CW)) point_ch ();
  pno_result_if #(.COORD_WIDTH(CW)) result_ch ();

  polyline_normal_offset #(.COORD_WIDTH(CW)) dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .point_in   (point_ch),
    .result_out (result_ch)
  );

  // Shadow of the block: offset distance, the two most recent points and the count.
  logic [DW-1:0] offset_dist;
  longint hist_x[2];
  longint hist_y[2];
  int line_count;
  offset_result_t expected_offsets[$];

  int mismatches;
  int points_sent;
  int lines_sent;
  int results_checked;
  int zero_results;
  int burst_left;

  int rx_tick;
  int rx_period;
  int rx_hold;

  always #10 clk = ~clk;

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 64'd0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 64'd0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Offset vector d*n for the chord (x0,y0) -> (x2,y2); returns 1 for a zero chord.
  function automatic bit chord_normal(input longint x0, y0, x2, y2,
                                      output longint ox, oy);
    longint tx;
    longint ty;
    logic [63:0] ax, ay, m, r, ux, uy, mx, my, dd;
    tx = y2 - y0;
    ty = x0 - x2;
    ax = (tx < 0) ? -tx : tx;
    ay = (ty < 0) ? -ty : ty;
    ox = 0;
    oy = 0;
    if (ax == 0 && ay == 0) return 1'b1;
    m = (ax > ay) ? ax : ay;
    // Scale both magnitudes together until the larger one has its top bit at 30.
    while (m >= (64'd1 << 31)) begin
      ax = ax >> 1;
      ay = ay >> 1;
      m = m >> 1;
    end
    while (m < (64'd1 << 30)) begin
      ax = ax << 1;
      ay = ay << 1;
      m = m << 1;
    end
    r = floor_root(ax * ax + ay * ay);
    ux = (ax << 30) / r;
    uy = (ay << 30) / r;
    dd = 64'(offset_dist);
    mx = (dd * ux + (64'd1 << 29)) >> 30;
    my = (dd * uy + (64'd1 << 29)) >> 30;
    ox = (tx < 0) ? -longint'(mx) : longint'(mx);
    oy = (ty < 0) ? -longint'(my) : longint'(my);
    return 1'b0;
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(longint v);
    if (v > COORD_MAX) return C_MAX;
    if (v < COORD_MIN) return C_MIN;
    return v[CW-1:0];
  endfunction

  function automatic void push_offset(longint px, py, ox, oy, bit zc, bit fin);
    offset_result_t e;
    e.plus_x = clamp_coord(px + ox);
    e.plus_y = clamp_coord(py + oy);
    e.minus_x = clamp_coord(px - ox);
    e.minus_y = clamp_coord(py - oy);
    e.zero_chord = zc;
    e.last_result = fin;
    expected_offsets.insert(expected_offsets.size(), e);
  endfunction

  function automatic void shift_point(longint px, py);
    hist_x[0] = hist_x[1];
    hist_y[0] = hist_y[1];
    hist_x[1] = px;
    hist_y[1] = py;
  endfunction

  function automatic void predict_point(logic signed [CW-1:0] x, y, logic is_end);
    longint px;
    longint py;
    longint ox;
    longint oy;
    bit zc;
    px = longint'(x);
    py = longint'(y);
    if (line_count == 0) begin
      if (is_end) push_offset(0, 0, 0, 0, 1'b0, 1'b1);
      else begin
        shift_point(px, py);
        line_count = 1;
      end
    end else if (line_count == 1) begin
      if (is_end) begin
        push_offset(0, 0, 0, 0, 1'b0, 1'b0);
        push_offset(0, 0, 0, 0, 1'b0, 1'b1);
        line_count = 0;
      end else begin
        shift_point(px, py);
        line_count = 2;
      end
    end else begin
      zc = chord_normal(hist_x[0], hist_y[0], px, py, ox, oy);
      // The first point of a line borrows the normal of the second.
      if (line_count == 2) push_offset(hist_x[0], hist_y[0], ox, oy, zc, 1'b0);
      push_offset(hist_x[1], hist_y[1], ox, oy, zc, 1'b0);
      if (is_end) begin
        push_offset(px, py, ox, oy, zc, 1'b1);
        line_count = 0;
      end else begin
        shift_point(px, py);
        line_count = 3;
      end
    end
    if (line_count == 0) begin
      hist_x[0] = 0;
      hist_x[1] = 0;
      hist_y[0] = 0;
      hist_y[1] = 0;
    end
    if (is_end) lines_sent++;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] want, logic [63:0] got);
    if (mismatches < MAX_REPORTS)
      $display("MISMATCH at %0t: %s expected %h got %h", $realtime, what, want, got);
    mismatches++;
  endtask

  // A request is taken at an edge where valid and ready are both high.
  task automatic send_point(logic signed [CW-1:0] x, y, logic is_end);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        point_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    point_ch.valid <= 1'b1;
    point_ch.point_x <= x;
    point_ch.point_y <= y;
    point_ch.last_point <= is_end;
    @(posedge clk);
    while (!point_ch.ready) @(posedge clk);
    predict_point(x, y, is_end);
    burst_left--;
    points_sent++;
  endtask

  // Drop valid and let every pending result drain before touching the register.
  task automatic settle();
    point_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_offsets.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_distance(logic [DW-1:0] d);
    cfg_we <= 1'b1;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    offset_dist = d;
  endtask

  function automatic logic signed [CW-1:0] corner_coord();
    case ($urandom_range(0, 5))
      0: return C_MIN;
      1: return C_MAX;
      2: return '0;
      3: return '1;
      4: return 1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_line(int len, line_style_t style);
    logic signed [CW-1:0] x, y;
    logic signed [CW-1:0] x1, y1, x2, y2;
    longint spread;
    longint dx;
    longint dy;
    spread = (style == LINE_CREEP) ? $urandom_range(1, 4) : $urandom_range(1, 1 << 22);
    x1 = $urandom;
    y1 = $urandom;
    x2 = x1;
    y2 = y1;
    for (int i = 0; i < len; i++) begin
      dx = longint'($urandom_range(0, 32'(2 * spread))) - spread;
      dy = longint'($urandom_range(0, 32'(2 * spread))) - spread;
      case (style)
        LINE_SCATTER: begin
          x = $urandom;
          y = $urandom;
        end
        LINE_CORNERS: begin
          x = corner_coord();
          y = corner_coord();
        end
        default: begin
          x = (i == 0) ? x1 : CW'(x1 + dx);
          y = (i == 0) ? y1 : CW'(y1 + dy);
        end
      endcase
      // Coming back to the point two steps earlier makes the chord vanish.
      if (i >= 2 && $urandom_range(0, 9) == 0) begin
        x = x2;
        y = y2;
      end
      send_point(x, y, i == len - 1);
      x2 = x1;
      y2 = y1;
      x1 = x;
      y1 = y;
    end
  endtask

  task automatic test_short_lines();
    send_point(32'sh0001_0000, 32'sh0002_0000, 1'b1);
    send_point(C_MAX, C_MIN, 1'b0);
    send_point(C_MIN, C_MAX, 1'b1);
  endtask

  task automatic test_reset_distance();
    send_point(32'sh0010_0000, 32'sh0000_0000, 1'b0);
    send_point(32'sh0011_0000, 32'sh0001_0000, 1'b0);
    send_point(32'sh0012_0000, 32'sh0000_0000, 1'b1);
  endtask

  task automatic test_extremes();
    // Huge chords force a right shift; the offsets push the outputs into saturation.
    send_point(C_MIN, C_MIN, 1'b0);
    send_point('0, '0, 1'b0);
    send_point(C_MAX, C_MAX, 1'b1);
    send_point(C_MAX, C_MIN, 1'b0);
    send_point(C_MIN, C_MAX, 1'b0);
    send_point(C_MIN, C_MIN, 1'b1);
    // Chords of one LSB need the widest left shift.
    send_point('0, '0, 1'b0);
    send_point(1, '0, 1'b0);
    send_point('0, 1, 1'b0);
    send_point(1, 1, 1'b1);
  endtask

  task automatic test_zero_chord();
    send_point(32'sh0005_0000, 32'sh0005_0000, 1'b0);
    send_point(32'sh0009_0000, 32'sh0002_0000, 1'b0);
    send_point(32'sh0005_0000, 32'sh0005_0000, 1'b0);
    send_point(32'sh0007_0000, 32'sh0007_0000, 1'b1);
    send_point(32'sh7000_0000, -32'sh7000_0000, 1'b0);
    send_point(32'sh7000_0000, -32'sh7000_0000, 1'b0);
    send_point(32'sh7000_0000, -32'sh7000_0000, 1'b1);
  endtask

  task automatic test_random_lines(int target);
    int start;
    int len;
    int pick;
    start = points_sent;
    while (points_sent - start < target) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
      pick = $urandom_range(0, 4);
      send_line(len, (pick == 4) ? LINE_WALK : line_style_t'(pick));
    end
  endtask

  // The receiver picks a new stall pattern every so often, sometimes one with no stalls.
  always @(posedge clk) begin
    if (rx_tick == 0) begin
      rx_period = $urandom_range(1, 9);
      rx_hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, rx_period - 1);
    end
    result_ch.ready <= (rx_tick % rx_period) >= rx_hold;
    rx_tick = (rx_tick + 1) % 97;
  end

  always @(posedge clk) begin : result_check
    offset_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_offsets.size() == 0) begin
        report_mismatch("result with nothing expected", '0, '0);
      end else begin
        want = expected_offsets.pop_front();
        if (result_ch.plus_x !== want.plus_x)
          report_mismatch("plus_x", want.plus_x, result_ch.plus_x);
        if (result_ch.plus_y !== want.plus_y)
          report_mismatch("plus_y", want.plus_y, result_ch.plus_y);
        if (result_ch.minus_x !== want.minus_x)
          report_mismatch("minus_x", want.minus_x, result_ch.minus_x);
        if (result_ch.minus_y !== want.minus_y)
          report_mismatch("minus_y", want.minus_y, result_ch.minus_y);
        if (result_ch.zero_chord !== want.zero_chord)
          report_mismatch("zero_chord", want.zero_chord, result_ch.zero_chord);
        if (result_ch.last_result !== want.last_result)
          report_mismatch("last_result", want.last_result, result_ch.last_result);
      end
      results_checked++;
      if (result_ch.zero_chord === 1'b1) zero_results++;
    end
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    point_ch.valid = 1'b0;
    point_ch.point_x = '0;
    point_ch.point_y = '0;
    point_ch.last_point = 1'b0;
    result_ch.ready = 1'b0;
    rx_tick = 0;
    rx_period = 1;
    rx_hold = 0;
    offset_dist = '0;
    hist_x = '{0, 0};
    hist_y = '{0, 0};
    line_count = 0;
    mismatches = 0;
    points_sent = 0;
    lines_sent = 0;
    results_checked = 0;
    zero_results = 0;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_lines();
    test_reset_distance();
    settle();
    write_distance(DIST_MAX);
    test_extremes();
    test_zero_chord();

    settle();
    test_random_lines(85);
    settle();
    write_distance('0);
    test_random_lines(80);
    settle();
    write_distance(DW'($urandom));
    test_random_lines(85);
    settle();
    write_distance(DW'($urandom_range(1, 1 << 20)));
    test_random_lines(85);
    settle();

    $display("summary: %0d points in %0d lines, %0d results checked, %0d on a zero chord",
             points_sent, lines_sent, results_checked, zero_results);
    $display("summary: offset distance swept over zero, full scale and random values");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
design/pno_pkg.sv
design/pno_point_if.sv
design/pno_result_if.sv
design/pno_norm_unit.sv
design/polyline_normal_offset.sv
test/polyline_normal_offset_tb.sv
